### hdl/sat_pkg.sv
// Shared types and codes for the sorted array table.
package sat_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned CNT_W   = 5;

    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctl;

endpackage

### hdl/sorted_array_table.sv
// Top level of the sorted array table: cell row, control and result register.
//
//  channel   dir  tdata (low bit up)                     tuser
//  s_axis    in   value[31:0], position[35:32], pad      action[1:0]
//  m_axis    out  count[4:0], read_value[36:5], pad      status[1:0]
//
// One transaction per cycle while results are taken: every cell compares its entry to the key in
// parallel and shifts with its neighbor in the same cycle, so the result
// appears in the output register in the cycle after acceptance.
// Synchronous active-low reset empties the table and drops the result.
// A stalled result holds; a new transaction is taken when the result is taken.
module sorted_array_table #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // value[31:0], position[35:32]
    input  logic [1:0]  i_s_axis_tuser,   // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // count[4:0], read_value[36:5]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    localparam int unsigned CW     = $clog2(CAPACITY + 1);
    localparam int unsigned RD_N   = (CAPACITY < 16) ? CAPACITY : 16;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_m_valid;
    logic [39:0]   r_m_tdata;
    logic [1:0]    r_m_tuser;

    logic signed [sat_pkg::VALUE_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]                w_lt;
    logic [CAPACITY-1:0]                w_hit;
    logic [CAPACITY-1:0]                w_valid;

    sat_pkg::t_cell_ctl                 w_ctl;
    sat_pkg::t_action                   w_act;
    sat_pkg::t_status                   w_status;
    logic                               w_accept;
    logic                               w_full;
    logic                               w_found;
    logic                               w_in_range;
    logic signed [sat_pkg::VALUE_W-1:0] w_value;
    logic [sat_pkg::POS_W-1:0]          w_pos;
    logic signed [sat_pkg::VALUE_W-1:0] w_rd;
    logic [31:0]                        w_cnt32;

    assign w_value  = i_s_axis_tdata[31:0];
    assign w_pos    = i_s_axis_tdata[35:32];
    assign w_act    = sat_pkg::t_action'(i_s_axis_tuser);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_found  = |w_hit;
    assign w_in_range = (32'(w_pos) < 32'(r_count));

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;

    always_comb begin
        w_ctl.value = w_value;
        w_ctl.ins   = w_accept && (w_act == sat_pkg::ACT_INSERT) && !w_full;
        w_ctl.rem   = w_accept && (w_act == sat_pkg::ACT_REMOVE) && w_found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign w_valid[gi] = (CW'(gi) < r_count);
            sat_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_valid   (w_valid[gi]),
                .i_lt_prev ((gi == 0) ? 1'b1 : w_lt[(gi == 0) ? 0 : gi - 1]),
                .i_left    (w_entry[(gi == 0) ? 0 : gi - 1]),
                .i_right   (w_entry[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .o_entry   (w_entry[gi]),
                .o_lt      (w_lt[gi]),
                .o_hit     (w_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        w_rd = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (w_pos == sat_pkg::POS_W'(i)) begin
                w_rd = w_entry[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        w_status = sat_pkg::ST_OK;
        unique case (w_act)
            sat_pkg::ACT_INSERT: begin
                if (w_full) begin
                    w_status = sat_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            sat_pkg::ACT_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CW'(1);
                end else begin
                    w_status = sat_pkg::ST_NOT_FOUND;
                end
            end
            sat_pkg::ACT_READ: begin
                if (!w_in_range) begin
                    w_status = sat_pkg::ST_RANGE;
                end
            end
            default: begin
                w_status = sat_pkg::ST_OK;
            end
        endcase
    end

    assign w_cnt32 = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_tuser       <= w_status;
            r_m_tdata[4:0]  <= w_cnt32[sat_pkg::CNT_W-1:0];
            r_m_tdata[36:5] <= (w_act == sat_pkg::ACT_READ && w_in_range) ? w_rd : '0;
            r_m_tdata[39:37] <= '0;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;

endmodule

### hdl/sat_cell.sv
// One table slot: holds an entry, compares it to the key and shifts with its neighbors.
module sat_cell (
    input  logic                                 i_clk,
    input  sat_pkg::t_cell_ctl                   i_ctl,
    input  logic                                 i_valid,
    input  logic                                 i_lt_prev,
    input  logic signed [sat_pkg::VALUE_W-1:0]   i_left,
    input  logic signed [sat_pkg::VALUE_W-1:0]   i_right,
    output logic signed [sat_pkg::VALUE_W-1:0]   o_entry,
    output logic                                 o_lt,
    output logic                                 o_hit
);

    logic signed [sat_pkg::VALUE_W-1:0] r_entry;
    logic signed [sat_pkg::VALUE_W-1:0] n_entry;

    assign o_entry = r_entry;
    assign o_lt    = i_valid && (r_entry < i_ctl.value);
    // lower-bound slot holding an equal value
    assign o_hit   = i_valid && !o_lt && i_lt_prev && (r_entry == i_ctl.value);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_lt) begin
            n_entry = i_lt_prev ? i_ctl.value : i_left;
        end else if (i_ctl.rem && !o_lt) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### hdl/sat_chk.sv
// Port-level assertions for the sorted array table, bound to the top level.
module sat_chk #(
    parameter int unsigned CAPACITY = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [39:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    localparam logic [4:0] CAP_LOW = 5'(CAPACITY);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted transaction gave no result");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == sat_pkg::ST_RANGE) |->
            o_m_axis_tdata[36:5] == 32'd0)
        else $error("out-of-range read returned data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == sat_pkg::ST_FULL) |->
            o_m_axis_tdata[4:0] == CAP_LOW)
        else $error("full status with count below capacity");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_array_table sat_chk #(.CAPACITY(CAPACITY)) u_sat_chk (.*);

### bench/tb_sorted_array_table.sv
// Testbench for the sorted array table: directed and random stream traffic against a shadow table.
module tb_sorted_array_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  CAPACITY   = 16;
    localparam logic [1:0]   ACT_UNUSED = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        sat_pkg::t_status             status;
        logic [sat_pkg::CNT_W-1:0]    count;
        logic signed [31:0]           read_value;
    } t_table_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // value[31:0], position[35:32]
    logic [1:0]  i_s_axis_tuser = '0;   // action[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // count[4:0], read_value[36:5]
    logic [1:0]  o_m_axis_tuser;        // status[1:0]

    // shadow copy of the table contents
    logic signed [31:0] shadow_tbl [CAPACITY];
    int unsigned        shadow_cnt = 0;

    t_table_reply pending_replies [$];
    int unsigned  error_count = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;

    sorted_array_table #(.CAPACITY(CAPACITY)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // updates the shadow table and returns the reply the block should give
    function automatic t_table_reply table_apply(logic [1:0] act, logic signed [31:0] v,
                                                 logic [3:0] pos);
        t_table_reply r;
        int unsigned  lb;
        r.status     = sat_pkg::ST_OK;
        r.read_value = '0;
        lb = 0;
        while (lb < shadow_cnt && shadow_tbl[lb] < v)
            lb++;
        if (act == sat_pkg::ACT_INSERT) begin
            if (shadow_cnt >= CAPACITY) begin
                r.status = sat_pkg::ST_FULL;
            end else begin
                for (int unsigned i = shadow_cnt; i > lb; i--)
                    shadow_tbl[i] = shadow_tbl[i-1];
                shadow_tbl[lb] = v;
                shadow_cnt++;
            end
        end else if (act == sat_pkg::ACT_REMOVE) begin
            if (lb < shadow_cnt && shadow_tbl[lb] == v) begin
                for (int unsigned i = lb + 1; i < shadow_cnt; i++)
                    shadow_tbl[i-1] = shadow_tbl[i];
                shadow_cnt--;
            end else begin
                r.status = sat_pkg::ST_NOT_FOUND;
            end
        end else if (act == sat_pkg::ACT_READ) begin
            if (pos < shadow_cnt)
                r.read_value = shadow_tbl[pos];
            else
                r.status = sat_pkg::ST_RANGE;
        end
        r.count = shadow_cnt[sat_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic signed [31:0] pick_value(bit prefer_present);
        logic signed [31:0] v;
        int unsigned        r;
        if (prefer_present && shadow_cnt > 0 && $urandom_range(99) < 65)
            return shadow_tbl[$urandom_range(shadow_cnt - 1)];
        r = $urandom_range(99);
        if (r < 45) begin
            v = $urandom_range(16);
            return v - 32'sd8;
        end
        if (r < 70) begin
            case ($urandom_range(5))
                0: v = VAL_MIN;
                1: v = VAL_MAX;
                2: v = 32'sd0;
                3: v = -32'sd1;
                4: v = VAL_MIN + 32'sd1;
                default: v = VAL_MAX - 32'sd1;
            endcase
            return v;
        end
        return $urandom;
    endfunction

    task automatic send_op(input logic [1:0] act, input logic signed [31:0] v,
                           input logic [3:0] pos);
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, pos, v};
        i_s_axis_tuser  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_replies.push_back(table_apply(act, v, pos));
        gap = tx_idle_on ? idle_len() : 0;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every outstanding reply is back
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic run_random_ops(int unsigned n_items, int unsigned insert_pct);
        logic [1:0]         act;
        logic signed [31:0] v;
        logic [3:0]         pos;
        int unsigned        r;
        for (int unsigned k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 3)
                act = ACT_UNUSED;
            else if (r < 23)
                act = sat_pkg::ACT_READ;
            else if ($urandom_range(99) < insert_pct)
                act = sat_pkg::ACT_INSERT;
            else
                act = sat_pkg::ACT_REMOVE;
            v   = pick_value(act == sat_pkg::ACT_REMOVE);
            pos = 4'($urandom_range(15));
            if (act == sat_pkg::ACT_READ && shadow_cnt > 0 && $urandom_range(99) < 75)
                pos = 4'($urandom_range(shadow_cnt - 1));
            send_op(act, v, pos);
        end
    endtask

    task automatic test_empty_table();
        send_op(sat_pkg::ACT_REMOVE, 32'sd5, 4'd0);
        send_op(sat_pkg::ACT_READ, 32'sd0, 4'd0);
        send_op(sat_pkg::ACT_READ, -32'sd1, 4'hf);
        send_op(ACT_UNUSED, -32'sd1, 4'ha);
    endtask

    task automatic test_fill_to_capacity();
        send_op(sat_pkg::ACT_INSERT, VAL_MAX, 4'd0);
        send_op(sat_pkg::ACT_INSERT, VAL_MIN, 4'hf);
        send_op(sat_pkg::ACT_INSERT, 32'sd0, 4'd0);
        send_op(sat_pkg::ACT_INSERT, -32'sd1, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sd1, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sd0, 4'd0);
        send_op(sat_pkg::ACT_INSERT, VAL_MAX, 4'd0);
        send_op(sat_pkg::ACT_INSERT, VAL_MIN + 32'sd1, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sd100, 4'd0);
        send_op(sat_pkg::ACT_INSERT, -32'sd100, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sd7, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sd7, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sh5555_5555, 4'h5);
        send_op(sat_pkg::ACT_INSERT, 32'shaaaa_aaaa, 4'ha);
        send_op(sat_pkg::ACT_INSERT, 32'sd42, 4'd0);
        send_op(sat_pkg::ACT_INSERT, -32'sd42, 4'd0);
        send_op(sat_pkg::ACT_INSERT, 32'sd3, 4'd0);      // table full
        send_op(sat_pkg::ACT_READ, 32'sd0, 4'hf);
        send_op(sat_pkg::ACT_READ, 32'sd0, 4'd0);
    endtask

    task automatic test_remove_cases();
        send_op(sat_pkg::ACT_REMOVE, 32'sd12345, 4'd0);
        send_op(sat_pkg::ACT_REMOVE, VAL_MIN, 4'd0);
        send_op(sat_pkg::ACT_REMOVE, 32'sd7, 4'd0);
    endtask

    task automatic test_mixed_traffic();
        run_random_ops(110, 50);
    endtask

    task automatic test_full_table_pressure();
        run_random_ops(80, 85);
    endtask

    task automatic test_drain_to_empty();
        run_random_ops(80, 15);
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_ops(80, 50);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_late_mix();
        run_random_ops(100, 60);
    endtask

    initial begin : rx_pacing
        int unsigned n;
        forever begin
            n = rx_idle_on ? idle_len() : 0;
            if (n != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_table_reply e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply status %0d count %0d value %0d", $time,
                         o_m_axis_tuser, o_m_axis_tdata[4:0], $signed(o_m_axis_tdata[36:5]));
                error_count++;
            end else begin
                e = pending_replies.pop_front();
                if (o_m_axis_tuser !== e.status) begin
                    $display("%0t: status expected %0d got %0d", $time, e.status,
                             o_m_axis_tuser);
                    error_count++;
                end
                if (o_m_axis_tdata[4:0] !== e.count) begin
                    $display("%0t: count expected %0d got %0d", $time, e.count,
                             o_m_axis_tdata[4:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[36:5] !== e.read_value) begin
                    $display("%0t: read_value expected %0d got %0d", $time, e.read_value,
                             $signed(o_m_axis_tdata[36:5]));
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_fill_to_capacity();
        test_remove_cases();
        settle();
        test_mixed_traffic();
        test_full_table_pressure();
        settle();
        test_drain_to_empty();
        test_back_to_back();
        settle();
        test_late_mix();
        settle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_sorted_array_table: clean");
        else
            $display("tb_sorted_array_table: errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_sorted_array_table: errors");
        $finish;
    end

endmodule
